### sv/rpc_pkg.sv
// Shared types and constants for the rigid pose composition block.
package rpc_pkg;

    typedef enum logic [1:0] {
        KIND_LOAD    = 2'd0,
        KIND_COMPOSE = 2'd1,
        KIND_INVERSE = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    // Quaternions are Q1.14 and translations Q15.16 in fixed 16 and 32 bit words.
    localparam int QUAT_FRAC_BITS  = 14;
    localparam int SHIFT_FRAC_BITS = 16;

    // Rounded translation terms are clamped to +-2^CLAMP_EXP before the add.
    localparam int CLAMP_EXP = 40;

    typedef struct packed {
        logic start;     // begin one compose item
        logic inverse;   // the right pose is inverted first
        logic load;      // store the left pose
    } t_cmd;

    typedef struct packed {
        logic done;      // result word registered
    } t_status;

endpackage

### sv/rigid_pose_compose.sv
// Top level of the rigid pose composition block.
//   channel | direction | handshake         | word
//   input   | in        | i_valid / o_ready | kind, quaternion, shift, marker id
//   result  | out       | o_valid / i_ready | quaternion, shift, id, clipped
// A load or an ignored item is taken and leaves the block ready. A compose item
// runs the eight-phase walk of the shared datapath, one phase per cycle; the
// datapath then registers its done flag, and the controller registers o_valid
// from it. The result word leaves when i_ready is high, and the next item is
// taken only after that, however long the result waits for i_ready.
// Reset sets the left pose to identity.
// A new item is taken only once the previous result word has been taken.
module rigid_pose_compose (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_kind,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    input  logic signed [31:0] i_shift_x,
    input  logic signed [31:0] i_shift_y,
    input  logic signed [31:0] i_shift_z,
    input  logic [15:0]        i_marker_id,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_res_quat_w,
    output logic signed [15:0] o_res_quat_x,
    output logic signed [15:0] o_res_quat_y,
    output logic signed [15:0] o_res_quat_z,
    output logic signed [31:0] o_res_shift_x,
    output logic signed [31:0] o_res_shift_y,
    output logic signed [31:0] o_res_shift_z,
    output logic [15:0]        o_res_id,
    output logic               o_clipped
);
    import rpc_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    rpc_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_kind, .i_marker_id,
        .o_valid, .i_ready, .o_res_id, .o_cmd(w_cmd), .i_status(w_status)
    );

    rpc_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_status(w_status),
        .i_quat_w, .i_quat_x, .i_quat_y, .i_quat_z,
        .i_shift_x, .i_shift_y, .i_shift_z,
        .o_res_quat_w, .o_res_quat_x, .o_res_quat_y, .o_res_quat_z,
        .o_res_shift_x, .o_res_shift_y, .o_res_shift_z, .o_clipped
    );
endmodule

### sv/rpc_datapath.sv
// Datapath: left pose store, shared product engine, rounding and saturation.
module rpc_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rpc_pkg::t_cmd         i_cmd,
    output rpc_pkg::t_status      o_status,
    input  logic signed [15:0]    i_quat_w,
    input  logic signed [15:0]    i_quat_x,
    input  logic signed [15:0]    i_quat_y,
    input  logic signed [15:0]    i_quat_z,
    input  logic signed [31:0]    i_shift_x,
    input  logic signed [31:0]    i_shift_y,
    input  logic signed [31:0]    i_shift_z,
    output logic signed [15:0]    o_res_quat_w,
    output logic signed [15:0]    o_res_quat_x,
    output logic signed [15:0]    o_res_quat_y,
    output logic signed [15:0]    o_res_quat_z,
    output logic signed [31:0]    o_res_shift_x,
    output logic signed [31:0]    o_res_shift_y,
    output logic signed [31:0]    o_res_shift_z,
    output logic                  o_clipped
);
    import rpc_pkg::*;

    // Rotation matrix entries are sums of products of 17-bit values: 36 bits.
    localparam int MW = 36;
    // Inverse path: first rotation gives a 70-bit vector; second adds 36+3.
    localparam int UW = 72;
    localparam int SW = 112;
    localparam int KC = 2 * QUAT_FRAC_BITS;
    localparam int KI = 4 * QUAT_FRAC_BITS;

    // Phase counter walks: 0 left matrix, 1 right matrix, 2 first rotation (inverse
    // items; otherwise the right shift is copied), 3 to 5 second rotation, one
    // 24-bit slice of the vector per phase, 6 quaternion product, 7 round and saturate.
    logic [2:0]  r_phase;
    logic        r_busy;
    logic        r_inv;

    logic signed [15:0] r_lq [4];
    logic signed [31:0] r_lt [3];
    logic signed [15:0] r_rq [4];
    logic signed [31:0] r_rt [3];

    logic signed [MW-1:0] r_ml [9];
    logic signed [MW-1:0] r_mr [9];
    logic signed [UW-1:0] r_u  [3];
    logic signed [SW-1:0] r_s  [3];
    logic signed [33:0]   r_b  [4];

    logic signed [15:0] r_oq [4];
    logic signed [31:0] r_ot [3];
    logic               r_clip;
    logic               r_done;

    // The negated parts of a conjugate need 17 bits to hold plus one.
    function automatic logic signed [MW-1:0] f_entry(
        input logic signed [16:0] w, input logic signed [16:0] x,
        input logic signed [16:0] y, input logic signed [16:0] z,
        input logic [3:0] idx);
        logic signed [MW-1:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
        logic signed [MW-1:0] r;
        begin
            ww = MW'(w * w); xx = MW'(x * x); yy = MW'(y * y); zz = MW'(z * z);
            xy = MW'(x * y); wz = MW'(w * z); xz = MW'(x * z);
            wy = MW'(w * y); yz = MW'(y * z); wx = MW'(w * x);
            case (idx)
                4'd0: r = ww + xx - yy - zz;
                4'd1: r = (xy - wz) <<< 1;
                4'd2: r = (xz + wy) <<< 1;
                4'd3: r = (xy + wz) <<< 1;
                4'd4: r = ww - xx + yy - zz;
                4'd5: r = (yz - wx) <<< 1;
                4'd6: r = (xz - wy) <<< 1;
                4'd7: r = (yz + wx) <<< 1;
                default: r = ww - xx - yy + zz;
            endcase
            f_entry = r;
        end
    endfunction

    // One row of the left matrix times one 24-bit slice of the vector.
    // The top slice carries the sign; the lower two are unsigned.
    function automatic logic signed [SW-1:0] f_slice_dot(input int row, input int sl);
        logic signed [SW-1:0] acc;
        logic signed [24:0]   part;
        begin
            acc = '0;
            for (int j = 0; j < 3; j++) begin
                if (sl == 2)
                    part = 25'($signed(r_u[j][71:48]));
                else
                    part = $signed({1'b0, r_u[j][24*sl +: 24]});
                acc = acc + SW'(r_ml[3*row+j] * part);
            end
            f_slice_dot = acc;
        end
    endfunction

    // Round to nearest after dividing by 2^k, clamp to +-2^40.
    function automatic logic signed [41:0] f_round(input logic signed [SW-1:0] a,
                                                   input int k);
        logic signed [SW-1:0] t;
        begin
            t = (a + (SW'(1) <<< (k - 1))) >>> k;
            if (t > SW'(64'sd1 <<< CLAMP_EXP))
                f_round = 42'sd1 <<< CLAMP_EXP;
            else if (t < -SW'(64'sd1 <<< CLAMP_EXP))
                f_round = -(42'sd1 <<< CLAMP_EXP);
            else
                f_round = t[41:0];
        end
    endfunction

    logic signed [16:0] c_rx, c_ry, c_rz;
    always_comb begin
        c_rx = r_inv ? -17'(r_rq[1]) : 17'(r_rq[1]);
        c_ry = r_inv ? -17'(r_rq[2]) : 17'(r_rq[2]);
        c_rz = r_inv ? -17'(r_rq[3]) : 17'(r_rq[3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= '0;
            r_done  <= 1'b0;
            r_lq[0] <= 16'(1 << QUAT_FRAC_BITS);
            r_lq[1] <= '0; r_lq[2] <= '0; r_lq[3] <= '0;
            r_lt[0] <= '0; r_lt[1] <= '0; r_lt[2] <= '0;
        end else begin
            r_done <= r_busy && (r_phase == 3'd7);
            if (i_cmd.load) begin
                r_lq[0] <= i_quat_w; r_lq[1] <= i_quat_x;
                r_lq[2] <= i_quat_y; r_lq[3] <= i_quat_z;
                r_lt[0] <= i_shift_x; r_lt[1] <= i_shift_y; r_lt[2] <= i_shift_z;
            end
            if (i_cmd.start) begin
                r_busy  <= 1'b1;
                r_phase <= '0;
                r_inv   <= i_cmd.inverse;
                r_rq[0] <= i_quat_w; r_rq[1] <= i_quat_x;
                r_rq[2] <= i_quat_y; r_rq[3] <= i_quat_z;
                r_rt[0] <= i_shift_x; r_rt[1] <= i_shift_y; r_rt[2] <= i_shift_z;
            end else if (r_busy) begin
                r_phase <= r_phase + 3'd1;
                case (r_phase)
                    3'd0: for (int i = 0; i < 9; i++)
                        r_ml[i] <= f_entry(17'(r_lq[0]), 17'(r_lq[1]),
                                           17'(r_lq[2]), 17'(r_lq[3]), 4'(i));
                    3'd1: for (int i = 0; i < 9; i++)
                        r_mr[i] <= f_entry(17'(r_rq[0]), c_rx, c_ry, c_rz, 4'(i));
                    3'd2: for (int i = 0; i < 3; i++)
                        if (r_inv)
                            r_u[i] <= -(UW'(r_mr[3*i] * r_rt[0])
                                      + UW'(r_mr[3*i+1] * r_rt[1])
                                      + UW'(r_mr[3*i+2] * r_rt[2]));
                        else
                            r_u[i] <= UW'(r_rt[i]);
                    3'd3: for (int i = 0; i < 3; i++)
                        r_s[i] <= f_slice_dot(i, 0);
                    3'd4: for (int i = 0; i < 3; i++)
                        r_s[i] <= r_s[i] + (f_slice_dot(i, 1) <<< 24);
                    3'd5: for (int i = 0; i < 3; i++)
                        r_s[i] <= r_s[i] + (f_slice_dot(i, 2) <<< 48);
                    3'd6: begin
                        r_b[0] <= 34'(r_lq[0]*r_rq[0]) - 34'(r_lq[1]*c_rx)
                                - 34'(r_lq[2]*c_ry) - 34'(r_lq[3]*c_rz);
                        r_b[1] <= 34'(r_lq[0]*c_rx) + 34'(r_lq[1]*r_rq[0])
                                + 34'(r_lq[2]*c_rz) - 34'(r_lq[3]*c_ry);
                        r_b[2] <= 34'(r_lq[0]*c_ry) - 34'(r_lq[1]*c_rz)
                                + 34'(r_lq[2]*r_rq[0]) + 34'(r_lq[3]*c_rx);
                        r_b[3] <= 34'(r_lq[0]*c_rz) + 34'(r_lq[1]*c_ry)
                                - 34'(r_lq[2]*c_rx) + 34'(r_lq[3]*r_rq[0]);
                    end
                    default: begin
                        logic clip;
                        logic signed [41:0] rq;
                        logic signed [42:0] rt;
                        clip = 1'b0;
                        for (int i = 0; i < 4; i++) begin
                            rq = f_round(SW'(r_b[i]), QUAT_FRAC_BITS);
                            if (rq > 42'sd32767) begin
                                r_oq[i] <= 16'sh7fff; clip = 1'b1;
                            end else if (rq < -42'sd32768) begin
                                r_oq[i] <= 16'sh8000; clip = 1'b1;
                            end else
                                r_oq[i] <= rq[15:0];
                        end
                        for (int i = 0; i < 3; i++) begin
                            rt = 43'(r_lt[i]) + 43'(f_round(r_s[i], r_inv ? KI : KC));
                            if (rt > 43'sh7fffffff) begin
                                r_ot[i] <= 32'sh7fffffff; clip = 1'b1;
                            end else if (rt < -43'sh80000000) begin
                                r_ot[i] <= 32'sh80000000; clip = 1'b1;
                            end else
                                r_ot[i] <= rt[31:0];
                        end
                        r_clip <= clip;
                        r_busy <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign o_status.done = r_done;
    assign o_res_quat_w  = r_oq[0];
    assign o_res_quat_x  = r_oq[1];
    assign o_res_quat_y  = r_oq[2];
    assign o_res_quat_z  = r_oq[3];
    assign o_res_shift_x = r_ot[0];
    assign o_res_shift_y = r_ot[1];
    assign o_res_shift_z = r_ot[2];
    assign o_clipped     = r_clip;
endmodule

### sv/rpc_ctrl.sv
// Controller: input and output handshakes and sequencing of the datapath.
module rpc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_kind,
    input  logic [15:0]       i_marker_id,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [15:0]       o_res_id,
    output rpc_pkg::t_cmd     o_cmd,
    input  rpc_pkg::t_status  i_status
);
    import rpc_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_WORK, ST_OUT} t_state;
    t_state      r_state;
    logic [15:0] r_id;
    logic        r_valid;
    logic        c_acc;

    assign o_ready = (r_state == ST_IDLE);
    assign c_acc   = i_valid && o_ready;

    always_comb begin
        o_cmd.load    = c_acc && (t_kind'(i_kind) == KIND_LOAD);
        o_cmd.start   = c_acc && (t_kind'(i_kind) == KIND_COMPOSE
                                  || t_kind'(i_kind) == KIND_INVERSE);
        o_cmd.inverse = t_kind'(i_kind) == KIND_INVERSE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: if (o_cmd.start) begin
                    r_state <= ST_WORK;
                    r_id    <= i_marker_id;
                end
                ST_WORK: if (i_status.done) begin
                    r_state <= ST_OUT;
                    r_valid <= 1'b1;
                end
                ST_OUT: if (i_ready) begin
                    r_state <= ST_IDLE;
                    r_valid <= 1'b0;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid  = r_valid;
    assign o_res_id = r_id;
endmodule

### sv/rpc_checker.sv
// Port-level checks for the rigid pose composition block, bound to the top.
module rpc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [1:0]  i_kind,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_res_id
);
    import rpc_pkg::*;

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res_id))
        else $error("result word dropped while stalled");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input taken while a result is pending");
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_kind == KIND_LOAD |=> !o_valid)
        else $error("load item produced a result");
    a_compose_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_kind == KIND_COMPOSE || i_kind == KIND_INVERSE)
        |=> !o_ready)
        else $error("compose item did not occupy the block");
endmodule

bind rigid_pose_compose rpc_checker u_rpc_checker (
    .i_clk, .i_rst_n, .i_valid, .o_ready, .i_kind, .o_valid, .i_ready, .o_res_id
);
